// ===== rtl/core/bctm_pkg.sv =====
// shared types, constants and hash mix for the block coverage trace monitor
// used by the controller, datapath and top level; no dependencies
package bctm_pkg;

  localparam int SET_DEPTH    = 4096;
  localparam int RING_DEPTH   = 1024;
  localparam int IGNORE_SLOTS = 4;
  localparam int SET_AW       = $clog2(SET_DEPTH);
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int CFG_AW       = 3;

  localparam logic [63:0] MIX_MULT     = 64'hff51afd7ed558ccd;
  localparam logic [32:0] IDLE_RUN_MAX = 33'h1ffffffff;
  localparam logic [31:0] IDLE_LIMIT_RST  = 32'd1000000;
  localparam logic [31:0] STALE_LIMIT_RST = 32'd50000000;

  localparam logic [1:0] CMD_EXEC   = 2'd0;
  localparam logic [1:0] CMD_XLATE  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] CAUSE_NONE  = 2'd0;
  localparam logic [1:0] CAUSE_IDLE  = 2'd1;
  localparam logic [1:0] CAUSE_STALE = 2'd2;

  localparam logic [CFG_AW-1:0] REG_IGN_A    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IGN_B    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_IGN_C    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_IGN_D    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_IGN_USED = 3'd4;
  localparam logic [CFG_AW-1:0] REG_IDLE_LIM = 3'd5;
  localparam logic [CFG_AW-1:0] REG_STALE_LIM = 3'd6;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] block_addr;
    logic [9:0]  entry_offset;
  } in_req_t;

  typedef struct packed {
    logic        stopped;
    logic [1:0]  stop_cause;
    logic [63:0] executed_total;
    logic [12:0] distinct_blocks;
    logic [10:0] retained_entries;
    logic [31:0] entry_addr;
    logic [31:0] entry_repeats;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MIX1, ST_MIX2, ST_MIX3, ST_MIX4,
    ST_PROBE_RD, ST_PROBE_CHK, ST_RING, ST_UPDATE, ST_READ, ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic mix1;
    logic mix2;
    logic mix3;
    logic mix4;
    logic probe_rd;
    logic probe_chk;
    logic ring;
    logic update;
    logic read;
    logic done;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic probe_end;
  } dp_sts_t;

endpackage

// ===== rtl/core/bctm_ctrl.sv =====
// controller state machine for the block coverage trace monitor
// depends on bctm_pkg
module bctm_ctrl import bctm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic [1:0] cmd,
  input  dp_sts_t  sts,
  output logic     busy,
  output dp_cmd_t  dcmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          if (cmd == CMD_EXEC)      state_nxt = ST_MIX1;
          else if (cmd == CMD_READ) state_nxt = ST_READ;
          else                      state_nxt = ST_DONE;
        end
      end
      ST_MIX1:      state_nxt = ST_MIX2;
      ST_MIX2:      state_nxt = ST_MIX3;
      ST_MIX3:      state_nxt = ST_MIX4;
      ST_MIX4:      state_nxt = ST_PROBE_RD;
      ST_PROBE_RD:  state_nxt = ST_PROBE_CHK;
      ST_PROBE_CHK: state_nxt = sts.probe_end ? ST_RING : ST_PROBE_RD;
      ST_RING:      state_nxt = ST_UPDATE;
      ST_UPDATE:    state_nxt = ST_DONE;
      ST_READ:      state_nxt = ST_DONE;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    dcmd = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR:     dcmd.clr_step = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        dcmd.load = start;
      end
      ST_MIX1:      dcmd.mix1 = 1'b1;
      ST_MIX2:      dcmd.mix2 = 1'b1;
      ST_MIX3:      dcmd.mix3 = 1'b1;
      ST_MIX4:      dcmd.mix4 = 1'b1;
      ST_PROBE_RD:  dcmd.probe_rd = 1'b1;
      ST_PROBE_CHK: dcmd.probe_chk = 1'b1;
      ST_RING:      dcmd.ring = 1'b1;
      ST_UPDATE:    dcmd.update = 1'b1;
      ST_READ:      dcmd.read = 1'b1;
      ST_DONE:      dcmd.done = 1'b1;
      default:      dcmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/bctm_dp.sv =====
// datapath: hash mix, set memory, trace ring, counters and stop logic
// depends on bctm_pkg
module bctm_dp import bctm_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  dp_cmd_t         dcmd,
  input  in_req_t         req,
  input  logic            cfg_we,
  input  logic [CFG_AW-1:0] cfg_idx,
  input  logic [31:0]     cfg_data,
  output dp_sts_t         sts,
  output logic            res_vld,
  output out_res_t        res
);

  logic [31:0] set_mem [SET_DEPTH];
  logic [31:0] ring_a_mem [RING_DEPTH];
  logic [31:0] ring_r_mem [RING_DEPTH];

  logic [31:0] ign_r [IGNORE_SLOTS];
  logic [2:0]  ign_used_r;
  logic [31:0] idle_lim_r, stale_lim_r;

  logic [SET_AW-1:0]  clr_ptr_r;
  logic [1:0]  cmd_r;
  logic [31:0] addr_r;
  logic [9:0]  off_r;
  logic [63:0] m_r;
  logic [31:0] pl_r, ph_r, ql_r;   // partial products
  logic [SET_AW-1:0] slot_r;
  logic [SET_AW:0]   probes_r;
  logic [31:0] set_q_r;
  logic [31:0] ra_q_r, rr_q_r;
  logic        ign_hit_r;

  logic [RING_AW-1:0] ring_next_r;
  logic ring_wrapped_r, ring_nonempty_r;
  logic [63:0] total_r, active_r, novelty_r;
  logic [12:0] distinct_r;
  logic [32:0] idle_run_r;
  logic        halt_r;
  logic [1:0]  code_r;
  logic        res_vld_r;
  logic [31:0] e_addr_r, e_rep_r;

  logic [31:0] key;
  logic [63:0] mixed;
  logic [RING_AW-1:0] newest_pos, rd_pos;
  logic [10:0] retained;
  logic        hit_any;
  logic [2:0]  lim;

  assign key        = addr_r | 32'd1;
  assign newest_pos = ring_next_r - RING_AW'(1);
  assign retained   = ring_wrapped_r ? 11'(RING_DEPTH) : {1'b0, ring_next_r};
  assign rd_pos     = (ring_wrapped_r ? ring_next_r : '0) + off_r[RING_AW-1:0];
  assign lim        = (ign_used_r > 3'(IGNORE_SLOTS)) ? 3'(IGNORE_SLOTS) : ign_used_r;
  assign mixed      = m_r ^ {33'd0, m_r[63:33]};

  always_comb begin
    hit_any = 1'b0;
    for (int i = 0; i < IGNORE_SLOTS; i++)
      if ((3'(i) < lim) && (ign_r[i] == req.block_addr)) hit_any = 1'b1;
  end

  assign sts.clr_last  = (clr_ptr_r == SET_AW'(SET_DEPTH - 1));
  assign sts.probe_end = (set_q_r == key) || (set_q_r == 32'd0) ||
                         (probes_r == (SET_AW+1)'(SET_DEPTH - 1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < IGNORE_SLOTS; i++) ign_r[i] <= '0;
      ign_used_r  <= '0;
      idle_lim_r  <= IDLE_LIMIT_RST;
      stale_lim_r <= STALE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IGN_A:     ign_r[0] <= cfg_data;
        REG_IGN_B:     ign_r[1] <= cfg_data;
        REG_IGN_C:     ign_r[2] <= cfg_data;
        REG_IGN_D:     ign_r[3] <= cfg_data;
        REG_IGN_USED:  ign_used_r <= cfg_data[2:0];
        REG_IDLE_LIM:  idle_lim_r <= cfg_data;
        REG_STALE_LIM: stale_lim_r <= cfg_data;
        default:       ;
      endcase
    end
  end

  // set memory: clearing sweep, probe read, insert
  always_ff @(posedge clk) begin
    if (dcmd.clr_step) set_mem[clr_ptr_r] <= '0;
    else if (dcmd.probe_chk && (set_q_r == 32'd0)) set_mem[slot_r] <= key;
    if (dcmd.probe_rd) set_q_r <= set_mem[slot_r];
  end

  // ring memories
  always_ff @(posedge clk) begin
    if (dcmd.ring) begin
      ra_q_r <= ring_a_mem[newest_pos];
      rr_q_r <= ring_r_mem[newest_pos];
    end else if (dcmd.read) begin
      ra_q_r <= ring_a_mem[rd_pos];
      rr_q_r <= ring_r_mem[rd_pos];
    end
    if (dcmd.update) begin
      if (ring_nonempty_r && ra_q_r == addr_r) ring_r_mem[newest_pos] <= rr_q_r + 32'd1;
      else begin
        ring_a_mem[ring_next_r] <= addr_r;
        ring_r_mem[ring_next_r] <= 32'd1;
      end
    end
  end

  // payload and hash pipeline
  always_ff @(posedge clk) begin
    if (dcmd.load) begin
      cmd_r     <= req.cmd;
      addr_r    <= req.block_addr;
      off_r     <= req.entry_offset;
      ign_hit_r <= hit_any;
    end
    // key < 2^32 so key ^ (key >> 33) is key; multiply in 32x32 parts
    if (dcmd.mix1) {ph_r, pl_r} <= key * MIX_MULT[31:0];
    if (dcmd.mix2) ql_r <= 32'(key * MIX_MULT[63:32]);
    if (dcmd.mix3) m_r  <= {ph_r + ql_r, pl_r};
    if (dcmd.mix4) begin
      slot_r   <= mixed[SET_AW-1:0];
      probes_r <= '0;
    end
    if (dcmd.probe_chk && !sts.probe_end) begin
      slot_r   <= slot_r + SET_AW'(1);
      probes_r <= probes_r + (SET_AW+1)'(1);
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_ptr_r <= '0;
      ring_next_r <= '0;
      ring_wrapped_r <= 1'b0;
      ring_nonempty_r <= 1'b0;
      total_r <= '0;
      active_r <= '0;
      novelty_r <= '0;
      distinct_r <= '0;
      idle_run_r <= '0;
      halt_r <= 1'b0;
      code_r <= CAUSE_NONE;
      res_vld_r <= 1'b0;
      e_addr_r <= '0;
      e_rep_r <= '0;
    end else begin
      res_vld_r <= dcmd.done;
      if (dcmd.clr_step) clr_ptr_r <= clr_ptr_r + SET_AW'(1);
      if (dcmd.load) begin
        e_addr_r <= '0;
        e_rep_r  <= '0;
        if (req.cmd == CMD_XLATE) novelty_r <= active_r;
      end
      if (dcmd.probe_chk && (set_q_r == 32'd0)) distinct_r <= distinct_r + 13'd1;
      // entry fetched into the ring read registers during the read state
      if (dcmd.done && (cmd_r == CMD_READ) && ({1'b0, off_r} < retained)) begin
        e_addr_r <= ra_q_r;
        e_rep_r  <= rr_q_r;
      end
      if (dcmd.update) begin
        total_r <= total_r + 64'd1;
        if (!(ring_nonempty_r && ra_q_r == addr_r)) begin
          ring_nonempty_r <= 1'b1;
          ring_next_r <= ring_next_r + RING_AW'(1);
          if (ring_next_r == RING_AW'(RING_DEPTH - 1)) ring_wrapped_r <= 1'b1;
        end
        if (ign_hit_r) begin
          novelty_r <= active_r;
          if (idle_run_r != IDLE_RUN_MAX) idle_run_r <= idle_run_r + 33'd1;
          if (((idle_run_r != IDLE_RUN_MAX) ? idle_run_r + 33'd1 : idle_run_r)
              > {1'b0, idle_lim_r} && !halt_r) begin
            halt_r <= 1'b1;
            code_r <= CAUSE_IDLE;
          end
        end else begin
          idle_run_r <= '0;
          active_r <= active_r + 64'd1;
          if ((active_r + 64'd1 - novelty_r) > {32'd0, stale_lim_r} && !halt_r) begin
            halt_r <= 1'b1;
            code_r <= CAUSE_STALE;
          end
        end
      end
    end
  end

  assign res_vld = res_vld_r;
  always_comb begin
    res.stopped          = halt_r;
    res.stop_cause       = code_r;
    res.executed_total   = total_r;
    res.distinct_blocks  = distinct_r;
    res.retained_entries = retained;
    res.entry_addr       = e_addr_r;
    res.entry_repeats    = e_rep_r;
  end

endmodule

// ===== rtl/core/block_coverage_trace_monitor_core.sv =====
// block coverage trace monitor, top level
// execute runs the hash mix states, a probe read and check per probe, the ring
// read, update and done; a read runs the read state then done; others only done
// throughput: one request at a time, a new request once busy drops
// reset: synchronous active low; then a clearing pass over all 4096 set memory
// entries with busy high (configuration writes still taken)
// the result strobe is one cycle wide and the receiver cannot stall it
module block_coverage_trace_monitor_core import bctm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  // request channel
  input  logic          start,
  output logic          busy,
  input  in_req_t       in_req,
  // result channel
  output logic          out_valid,
  output out_res_t      out_res,
  // configuration writes
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [31:0]   cfg_data
);

  dp_cmd_t dcmd;
  dp_sts_t sts;

  // configuration is always accepted
  assign cfg_ready = 1'b1;

  // controller: sequences hash, probe walk, ring update and status
  bctm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .cmd   (in_req.cmd),
    .sts   (sts),
    .busy  (busy),
    .dcmd  (dcmd)
  );

  // datapath: memories and counters
  bctm_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .dcmd     (dcmd),
    .req      (in_req),
    .cfg_we   (cfg_valid),
    .cfg_idx  (cfg_index),
    .cfg_data (cfg_data),
    .sts      (sts),
    .res_vld  (out_valid),
    .res      (out_res)
  );

endmodule
